FILE: rtl/rhc_pkg.sv
// Package for the RGB to HSV converter: default widths, fixed field widths
// and the flag bundle that travels down the divider chain.
// No dependencies.
`default_nettype none

package rhc_pkg;

  localparam int CHANNEL_BITS_DEF  = 8;
  localparam int HUE_FRAC_BITS_DEF = 6;

  // Integer part of the hue: degrees up to 359 need nine bits.
  localparam int HUE_INT_BITS = 9;
  localparam int HUE_DEGREES  = 360;
  localparam int HUE_SECTOR   = 60;

  // Saturation is always a 16-bit fraction of full scale.
  localparam int SAT_BITS = 16;

  typedef struct packed {
    logic gray;   // max equals min, so hue is forced to zero
    logic black;  // max is zero, so saturation is forced to zero
    logic neg;    // the hue numerator was negative
  } rhc_flags_t;

endpackage

`default_nettype wire

FILE: rtl/rhc_pixel_if.sv
// Stream interfaces for the RGB to HSV converter: one for RGB pixels in,
// one for HSV pixels out. Valid/ready handshake with payload.
// No dependencies.
`default_nettype none

interface rhc_rgb_if #(
  parameter int CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red_in;
  logic [CHANNEL_BITS-1:0] green_in;
  logic [CHANNEL_BITS-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface rhc_hsv_if #(
  parameter int CHANNEL_BITS = 8,
  parameter int HUE_BITS     = 15,
  parameter int SAT_BITS     = 16
);
  logic                    valid;
  logic                    ready;
  logic [HUE_BITS-1:0]     hue_out;
  logic [SAT_BITS-1:0]     saturation_out;
  logic [CHANNEL_BITS-1:0] value_out;

  modport source (output valid, output hue_out, output saturation_out,
                  output value_out, input ready);
  modport sink   (input valid, input hue_out, input saturation_out,
                  input value_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/rhc_front.sv
// Front stage of the RGB to HSV converter: max, min, delta, hue numerator
// and the two dividends, registered. Depends on rhc_pkg.
`default_nettype none

module rhc_front
  import rhc_pkg::*;
#(
  parameter int CHANNEL_BITS  = CHANNEL_BITS_DEF,
  parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
  parameter int STEPS         = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    up_valid,
  output logic                         up_ready,
  input  wire logic [CHANNEL_BITS-1:0] red,
  input  wire logic [CHANNEL_BITS-1:0] green,
  input  wire logic [CHANNEL_BITS-1:0] blue,
  output logic                         down_valid,
  input  wire logic                    down_ready,
  output logic [CHANNEL_BITS-1:0]      rem_h,
  output logic [STEPS-1:0]             acc_h,
  output logic [CHANNEL_BITS-1:0]      div_h,
  output logic [CHANNEL_BITS-1:0]      rem_s,
  output logic [STEPS-1:0]             acc_s,
  output logic [CHANNEL_BITS-1:0]      div_s,
  output rhc_flags_t                   flags,
  output logic [CHANNEL_BITS-1:0]      value
);

  localparam int CB        = CHANNEL_BITS;
  localparam int NW        = CB + 4;
  localparam int MW        = CB + 3;
  localparam int DW        = CB + STEPS;
  localparam int HUE_SCALE = HUE_SECTOR << HUE_FRAC_BITS;

  logic [CB-1:0]        hi;
  logic [CB-1:0]        lo;
  logic [CB-1:0]        delta;
  logic signed [NW-1:0] r_s;
  logic signed [NW-1:0] g_s;
  logic signed [NW-1:0] b_s;
  logic signed [NW-1:0] d_s;
  logic signed [NW-1:0] numer;
  logic [NW-1:0]        mag_full;
  logic [MW-1:0]        mag;
  logic [DW-1:0]        dividend_h;
  logic [DW-1:0]        dividend_s;
  logic                 take;

  always_comb begin
    hi = (red > green) ? red : green;
    if (blue > hi) begin
      hi = blue;
    end
    lo = (red < green) ? red : green;
    if (blue < lo) begin
      lo = blue;
    end
    delta = hi - lo;

    r_s = signed'(NW'(red));
    g_s = signed'(NW'(green));
    b_s = signed'(NW'(blue));
    d_s = signed'(NW'(delta));

    // Sector of the largest channel; red wins ties, then green.
    priority if (red == hi) begin
      numer = g_s - b_s;
    end else if (green == hi) begin
      numer = (d_s <<< 1) + b_s - r_s;
    end else begin
      numer = (d_s <<< 2) + r_s - g_s;
    end

    mag_full   = numer[NW-1] ? NW'(-numer) : NW'(numer);
    mag        = mag_full[MW-1:0];
    dividend_h = DW'(mag) * DW'(HUE_SCALE);
    dividend_s = DW'({delta, {SAT_BITS{1'b0}}}) - DW'(delta);
  end

  assign up_ready = !down_valid || down_ready;
  assign take     = up_valid && up_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rem_h       <= dividend_h[DW-1:STEPS];
      acc_h       <= dividend_h[STEPS-1:0];
      div_h       <= delta;
      rem_s       <= dividend_s[DW-1:STEPS];
      acc_s       <= dividend_s[STEPS-1:0];
      div_s       <= hi;
      flags.gray  <= (delta == '0);
      flags.black <= (hi == '0);
      flags.neg   <= numer[NW-1];
      value       <= hi;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rhc_cell.sv
// One cell of the divider chain: a restoring step for the hue and the
// saturation quotients, with a pipeline register. Depends on rhc_pkg.
`default_nettype none

module rhc_cell
  import rhc_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int STEPS        = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    up_valid,
  output logic                         up_ready,
  input  wire logic [CHANNEL_BITS-1:0] rem_h_in,
  input  wire logic [STEPS-1:0]        acc_h_in,
  input  wire logic [CHANNEL_BITS-1:0] div_h_in,
  input  wire logic [CHANNEL_BITS-1:0] rem_s_in,
  input  wire logic [STEPS-1:0]        acc_s_in,
  input  wire logic [CHANNEL_BITS-1:0] div_s_in,
  input  wire rhc_flags_t              flags_in,
  input  wire logic [CHANNEL_BITS-1:0] value_in,
  output logic                         down_valid,
  input  wire logic                    down_ready,
  output logic [CHANNEL_BITS-1:0]      rem_h,
  output logic [STEPS-1:0]             acc_h,
  output logic [CHANNEL_BITS-1:0]      div_h,
  output logic [CHANNEL_BITS-1:0]      rem_s,
  output logic [STEPS-1:0]             acc_s,
  output logic [CHANNEL_BITS-1:0]      div_s,
  output rhc_flags_t                   flags,
  output logic [CHANNEL_BITS-1:0]      value
);

  localparam int CB = CHANNEL_BITS;

  logic [CB:0]    t_h;
  logic [CB:0]    t_s;
  logic [CB:0]    diff_h;
  logic [CB:0]    diff_s;
  logic           ge_h;
  logic           ge_s;
  logic [CB-1:0]  rem_h_next;
  logic [CB-1:0]  rem_s_next;
  logic           take;

  // Bring down the next dividend bit; the quotient bit shifts in below.
  always_comb begin
    t_h        = {rem_h_in, acc_h_in[STEPS-1]};
    t_s        = {rem_s_in, acc_s_in[STEPS-1]};
    diff_h     = t_h - {1'b0, div_h_in};
    diff_s     = t_s - {1'b0, div_s_in};
    ge_h       = (t_h >= {1'b0, div_h_in});
    ge_s       = (t_s >= {1'b0, div_s_in});
    rem_h_next = ge_h ? diff_h[CB-1:0] : t_h[CB-1:0];
    rem_s_next = ge_s ? diff_s[CB-1:0] : t_s[CB-1:0];
  end

  assign up_ready = !down_valid || down_ready;
  assign take     = up_valid && up_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rem_h <= rem_h_next;
      acc_h <= {acc_h_in[STEPS-2:0], ge_h};
      div_h <= div_h_in;
      rem_s <= rem_s_next;
      acc_s <= {acc_s_in[STEPS-2:0], ge_s};
      div_s <= div_s_in;
      flags <= flags_in;
      value <= value_in;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rhc_back.sv
// Back stage of the RGB to HSV converter: sign and special-case fix-up of
// the quotients, and the output register. Depends on rhc_pkg.
`default_nettype none

module rhc_back
  import rhc_pkg::*;
#(
  parameter int CHANNEL_BITS  = CHANNEL_BITS_DEF,
  parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
  parameter int STEPS         = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              up_valid,
  output logic                                   up_ready,
  input  wire logic [STEPS-1:0]                  quot_h,
  input  wire logic [STEPS-1:0]                  quot_s,
  input  wire rhc_flags_t                        flags,
  input  wire logic [CHANNEL_BITS-1:0]           value,
  output logic                                   down_valid,
  input  wire logic                              down_ready,
  output logic [HUE_INT_BITS+HUE_FRAC_BITS-1:0]  hue,
  output logic [SAT_BITS-1:0]                    saturation,
  output logic [CHANNEL_BITS-1:0]                value_q
);

  localparam int HW       = HUE_INT_BITS + HUE_FRAC_BITS;
  localparam int HUE_FULL = HUE_DEGREES << HUE_FRAC_BITS;

  logic [HW-1:0]       q_h;
  logic [HW-1:0]       hue_next;
  logic [SAT_BITS-1:0] sat_next;
  logic                take;

  always_comb begin
    q_h = quot_h[HW-1:0];
    // A negative hue wraps by a full turn, unless it truncated to zero.
    priority if (flags.gray) begin
      hue_next = '0;
    end else if (flags.neg && (q_h != '0)) begin
      hue_next = HW'(HUE_FULL) - q_h;
    end else begin
      hue_next = q_h;
    end
    sat_next = flags.black ? '0 : quot_s[SAT_BITS-1:0];
  end

  assign up_ready = !down_valid || down_ready;
  assign take     = up_valid && up_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hue        <= hue_next;
      saturation <= sat_next;
      value_q    <= value;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rgb_to_hsv_converter.sv
// Top level of the RGB to HSV converter: front stage, divider chain of
// cells and back stage. Depends on rhc_pkg, the stream interfaces and
// rhc_front, rhc_cell and rhc_back.
//
// The converter takes one RGB pixel per transaction and returns its HSV form
// in one transaction, in stream order. It accepts a new pixel on every clock
// cycle unless the output stalls, and so sustains one pixel per cycle.
// A pixel passes the front register, each cell of the divider chain and the
// back register in turn. STEPS, the larger of 9 + HUE_FRAC_BITS and 16, is
// the width of both quotients. Each cell works out one quotient bit of the
// hue division and one of the saturation division. Every stage has its own
// valid bit and ready is derived stage by stage, so empty stages are filled
// while a finished result waits at the output. Hue is in degrees with
// HUE_FRAC_BITS fraction bits, truncated toward zero, with a negative hue
// wrapped by a full turn; a grey pixel gives hue zero. Saturation is
// delta * 65535 / max, truncated, and zero for a black pixel. Value is the
// largest channel. There are no configuration registers and no state is
// carried from one pixel to the next.
`default_nettype none

module rgb_to_hsv_converter
  import rhc_pkg::*;
#(
  parameter int CHANNEL_BITS  = CHANNEL_BITS_DEF,
  parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  rhc_rgb_if.sink  rgb,
  rhc_hsv_if.source hsv
);

  localparam int CB     = CHANNEL_BITS;
  localparam int HW     = HUE_INT_BITS + HUE_FRAC_BITS;
  // Both quotients fit in STEPS bits, so one chain serves the two divisions.
  localparam int STEPS  = (HW > SAT_BITS) ? HW : SAT_BITS;

  // Stage k of these arrays is the register set feeding cell k; stage 0 is
  // the front register and stage STEPS feeds the back stage.
  logic             st_valid [STEPS+1];
  logic             st_ready [STEPS+1];
  logic [CB-1:0]    st_rem_h [STEPS+1];
  logic [STEPS-1:0] st_acc_h [STEPS+1];
  logic [CB-1:0]    st_div_h [STEPS+1];
  logic [CB-1:0]    st_rem_s [STEPS+1];
  logic [STEPS-1:0] st_acc_s [STEPS+1];
  logic [CB-1:0]    st_div_s [STEPS+1];
  rhc_flags_t       st_flags [STEPS+1];
  logic [CB-1:0]    st_value [STEPS+1];

  rhc_front #(
    .CHANNEL_BITS  (CHANNEL_BITS),
    .HUE_FRAC_BITS (HUE_FRAC_BITS),
    .STEPS         (STEPS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (rgb.valid),
    .up_ready   (rgb.ready),
    .red        (rgb.red_in),
    .green      (rgb.green_in),
    .blue       (rgb.blue_in),
    .down_valid (st_valid[0]),
    .down_ready (st_ready[0]),
    .rem_h      (st_rem_h[0]),
    .acc_h      (st_acc_h[0]),
    .div_h      (st_div_h[0]),
    .rem_s      (st_rem_s[0]),
    .acc_s      (st_acc_s[0]),
    .div_s      (st_div_s[0]),
    .flags      (st_flags[0]),
    .value      (st_value[0])
  );

  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    rhc_cell #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .STEPS        (STEPS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (st_valid[k]),
      .up_ready   (st_ready[k]),
      .rem_h_in   (st_rem_h[k]),
      .acc_h_in   (st_acc_h[k]),
      .div_h_in   (st_div_h[k]),
      .rem_s_in   (st_rem_s[k]),
      .acc_s_in   (st_acc_s[k]),
      .div_s_in   (st_div_s[k]),
      .flags_in   (st_flags[k]),
      .value_in   (st_value[k]),
      .down_valid (st_valid[k+1]),
      .down_ready (st_ready[k+1]),
      .rem_h      (st_rem_h[k+1]),
      .acc_h      (st_acc_h[k+1]),
      .div_h      (st_div_h[k+1]),
      .rem_s      (st_rem_s[k+1]),
      .acc_s      (st_acc_s[k+1]),
      .div_s      (st_div_s[k+1]),
      .flags      (st_flags[k+1]),
      .value      (st_value[k+1])
    );
  end

  // After the last cell the accumulators hold the two quotients.
  rhc_back #(
    .CHANNEL_BITS  (CHANNEL_BITS),
    .HUE_FRAC_BITS (HUE_FRAC_BITS),
    .STEPS         (STEPS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (st_valid[STEPS]),
    .up_ready   (st_ready[STEPS]),
    .quot_h     (st_acc_h[STEPS]),
    .quot_s     (st_acc_s[STEPS]),
    .flags      (st_flags[STEPS]),
    .value      (st_value[STEPS]),
    .down_valid (hsv.valid),
    .down_ready (hsv.ready),
    .hue        (hsv.hue_out),
    .saturation (hsv.saturation_out),
    .value_q    (hsv.value_out)
  );

endmodule

`default_nettype wire

FILE: rtl/rhc_checker.sv
// Port-level checker for the RGB to HSV converter, bound to the top level.
// Depends on rhc_pkg and rgb_to_hsv_converter.
`default_nettype none

module rhc_checker
  import rhc_pkg::*;
#(
  parameter int CHANNEL_BITS  = CHANNEL_BITS_DEF,
  parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  out_valid,
  input wire logic                                  out_ready,
  input wire logic [HUE_INT_BITS+HUE_FRAC_BITS-1:0] hue,
  input wire logic [SAT_BITS-1:0]                   saturation,
  input wire logic [CHANNEL_BITS-1:0]               value
);

  localparam int HW       = HUE_INT_BITS + HUE_FRAC_BITS;
  localparam int HUE_FULL = HUE_DEGREES << HUE_FRAC_BITS;

  // Nothing is presented in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A held transaction stays valid.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output transaction dropped while stalled");

  // Hue stays below a full turn.
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hue < HW'(HUE_FULL)))
    else $error("hue out of range");

  // A black pixel has no saturation.
  a_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && (value == '0) |-> (saturation == '0))
    else $error("black pixel with saturation");

  // Zero saturation means a grey pixel, whose hue is zero.
  a_gray: assert property (@(posedge clk) disable iff (rst)
    out_valid && (saturation == '0) |-> (hue == '0))
    else $error("grey pixel with hue");

endmodule

bind rgb_to_hsv_converter rhc_checker #(
  .CHANNEL_BITS  (CHANNEL_BITS),
  .HUE_FRAC_BITS (HUE_FRAC_BITS)
) u_rhc_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (hsv.valid),
  .out_ready  (hsv.ready),
  .hue        (hsv.hue_out),
  .saturation (hsv.saturation_out),
  .value      (hsv.value_out)
);

`default_nettype wire
